[rtl/assert_macros.svh]
// Assertion macros used by the checker file vfsd_checker.sv.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define VFSD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vfsd assertion failed");

// clocked assertion that also holds through reset
`define VFSD_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("vfsd reset assertion failed");

`endif

[rtl/vfsd_pkg.sv]
// Types and constants of the vector frame stream decoder.
// Depends on nothing; used by the top level, the checker and the testbench.
`default_nettype none

package vfsd_pkg;

  localparam logic [7:0]  TERM_BYTE     = 8'd255;
  localparam logic [12:0] TERM_SCALED   = 13'd4095;
  localparam logic [7:0]  LINE_CLOSE    = 8'd96;
  localparam logic [15:0] BUDGET_RESET  = 16'd3000;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [12:0] y_value;
    logic [12:0] x_value;
    logic [15:0] end_index;
    logic        rewind;
    logic        bank;
    logic        last;
  } res_t;

  // (v * 4095) >> 7, done as (v << 12) - v
  function automatic logic [12:0] scale_byte(input logic [7:0] v);
    logic [19:0] prod;
    prod = {v, 12'b0} - {12'b0, v};
    return prod[19:7];
  endfunction

endpackage

`default_nettype wire

[rtl/vfsd_if.sv]
// Input and result channel interfaces with valid/ready handshake.
// Depends on nothing.
`default_nettype none

interface vfsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;
  logic       bank_select;

  modport source (output valid, output data_byte, output frame_start,
                  output bank_select, input ready);
  modport sink (input valid, input data_byte, input frame_start,
                input bank_select, output ready);
endinterface

interface vfsd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [12:0] y_value;
  logic [12:0] x_value;
  logic [15:0] end_index;
  logic        rewind;
  logic        bank;
  logic        last;

  modport source (output valid, output kind, output y_value, output x_value,
                  output end_index, output rewind, output bank, output last,
                  input ready);
  modport sink (input valid, input kind, input y_value, input x_value,
                input end_index, input rewind, input bank, input last,
                output ready);
endinterface

`default_nettype wire

[rtl/vector_frame_stream_decoder.sv]
// Top level of the vector frame stream decoder: byte decode and result queue.
// Depends on vfsd_pkg and the channel interfaces in vfsd_if.sv.
`default_nettype none

// One encoded byte is decoded per cycle: a single pass of logic from the input
// handshake into a two-entry result queue, which holds the up to two results
// (point, frame end) one byte can cause. A byte that yields one result or none
// is taken every cycle while results drain; a byte that yields two holds the
// input off until the first result has left. Input is accepted whenever the
// queue is empty, or holds one result that is being taken.
module vector_frame_stream_decoder
  import vfsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  vfsd_in_if.sink          in_chan,
  vfsd_out_if.source       out_chan,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0] budget_r;
  logic        aw_r, aw_nxt;
  logic [12:0] line_y_r, line_y_nxt;
  logic [15:0] pts_r, pts_nxt;
  logic [15:0] bc_r, bc_nxt;
  logic        fin_r, fin_nxt;
  res_t        s0_r, s0_nxt, s1_r, s1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  logic        accept, pop;
  logic        aw_s, fin_s;
  logic [15:0] pts_s, bc_s;
  logic        term, closes, is_point, is_end, rw;
  logic [7:0]  sv_in;
  logic [12:0] temp;
  res_t        pt_res, end_res;
  logic [1:0]  n_res;

  assign pop            = (cnt_r != 2'd0) && out_chan.ready;
  assign in_chan.ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_chan.ready);
  assign accept         = in_chan.valid && in_chan.ready;

  always_comb begin
    aw_s  = in_chan.frame_start ? 1'b1  : aw_r;
    fin_s = in_chan.frame_start ? 1'b0  : fin_r;
    pts_s = in_chan.frame_start ? 16'd0 : pts_r;
    bc_s  = in_chan.frame_start ? 16'd0 : bc_r;

    term     = (in_chan.data_byte == TERM_BYTE);
    closes   = (in_chan.data_byte > LINE_CLOSE);
    sv_in    = (!aw_s && closes) ? (in_chan.data_byte - LINE_CLOSE) : in_chan.data_byte;
    temp     = term ? TERM_SCALED : scale_byte(sv_in);
    is_point = !fin_s && !term && !aw_s;

    aw_nxt     = aw_s;
    line_y_nxt = line_y_r;
    pts_nxt    = pts_s;
    bc_nxt     = bc_s;
    fin_nxt    = fin_s;
    is_end     = 1'b0;
    rw         = 1'b0;

    if (!fin_s) begin
      if (!term && aw_s) begin
        line_y_nxt = temp;
        aw_nxt     = 1'b0;
      end
      if (is_point) begin
        pts_nxt = pts_s + 16'd1;
        if (closes) aw_nxt = 1'b1;
      end
      bc_nxt = bc_s + 16'd1;
      if (temp == TERM_SCALED) begin
        is_end = 1'b1;
      end else if (temp == 13'd0) begin
        is_end = 1'b1;
        rw     = 1'b1;
      end else if (bc_nxt >= budget_r) begin
        is_end = 1'b1;
      end
      if (is_end) fin_nxt = 1'b1;
    end

    pt_res.kind      = KIND_POINT;
    pt_res.y_value   = line_y_r;
    pt_res.x_value   = temp;
    pt_res.end_index = 16'd0;
    pt_res.rewind    = 1'b0;
    pt_res.bank      = in_chan.bank_select;
    pt_res.last      = !is_end;

    end_res.kind      = KIND_END;
    end_res.y_value   = 13'd0;
    end_res.x_value   = 13'd0;
    end_res.end_index = (pts_nxt != 16'd0) ? (pts_nxt - 16'd1) : 16'd0;
    end_res.rewind    = rw;
    end_res.bank      = in_chan.bank_select;
    end_res.last      = 1'b1;

    n_res = {1'b0, is_point} + {1'b0, is_end};

    s0_nxt  = s0_r;
    s1_nxt  = s1_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      s0_nxt  = is_point ? pt_res : end_res;
      s1_nxt  = end_res;
      cnt_nxt = n_res;
    end else if (pop) begin
      s0_nxt  = s1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_RESET;
      aw_r     <= 1'b1;
      line_y_r <= 13'd0;
      pts_r    <= 16'd0;
      bc_r     <= 16'd0;
      fin_r    <= 1'b1;
      cnt_r    <= 2'd0;
    end else begin
      if (cfg_we) budget_r <= cfg_wdata;
      if (accept) begin
        aw_r     <= aw_nxt;
        line_y_r <= line_y_nxt;
        pts_r    <= pts_nxt;
        bc_r     <= bc_nxt;
        fin_r    <= fin_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
  end

  assign out_chan.valid     = (cnt_r != 2'd0);
  assign out_chan.kind      = s0_r.kind;
  assign out_chan.y_value   = s0_r.y_value;
  assign out_chan.x_value   = s0_r.x_value;
  assign out_chan.end_index = s0_r.end_index;
  assign out_chan.rewind    = s0_r.rewind;
  assign out_chan.bank      = s0_r.bank;
  assign out_chan.last      = s0_r.last;

endmodule

`default_nettype wire

[rtl/vfsd_checker.sv]
// Port-level checker for the vector frame stream decoder, bound to the top.
// Depends on vfsd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vfsd_checker
  import vfsd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_kind,
  input wire logic [12:0] out_y_value,
  input wire logic [12:0] out_x_value,
  input wire logic [15:0] out_end_index,
  input wire logic        out_rewind,
  input wire logic        out_last
);

  `VFSD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_x_value) && $stable(out_last))
  `VFSD_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_valid)
  `VFSD_ASSERT(a_empty_ready, clk, rst_n, !out_valid |-> in_ready)
  `VFSD_ASSERT(a_end_fields, clk, rst_n, out_valid && (out_kind == KIND_END) |-> out_last && (out_y_value == 13'd0) && (out_x_value == 13'd0))
  `VFSD_ASSERT(a_point_fields, clk, rst_n, out_valid && (out_kind == KIND_POINT) |-> !out_rewind && (out_end_index == 16'd0))

endmodule

bind vector_frame_stream_decoder vfsd_checker u_vfsd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_kind      (out_chan.kind),
  .out_y_value   (out_chan.y_value),
  .out_x_value   (out_chan.x_value),
  .out_end_index (out_chan.end_index),
  .out_rewind    (out_chan.rewind),
  .out_last      (out_chan.last)
);

`default_nettype wire

[test/vector_frame_stream_decoder_tb.sv]
// Testbench for vector_frame_stream_decoder: directed and random byte streams
// with random idling on both channels, checked against a behavioral decoder.
// Depends on vfsd_pkg and the channel interfaces in vfsd_if.sv.
`default_nettype none

module vector_frame_stream_decoder_tb;
  import vfsd_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  vfsd_in_if  in_chan ();
  vfsd_out_if out_chan ();

  vector_frame_stream_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // decoder state as the block should hold it
  logic        want_line  = 1'b1;
  logic [12:0] cur_y      = '0;
  logic [15:0] pt_count   = '0;
  logic [15:0] byte_count = '0;
  logic        frame_idle = 1'b1;
  logic [15:0] byte_budget = BUDGET_RESET;

  res_t expected_results[$];
  int   mismatches   = 0;
  int   hold_cycles  = 0;
  logic in_steady    = 1'b0;
  logic out_steady   = 1'b0;

  always #5 clk = ~clk;

  function automatic logic [12:0] scaled_level(input logic [7:0] b);
    logic [19:0] prod;
    prod = {12'd0, b} * 20'd4095;
    return prod[19:7];
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic st, input logic bk);
    logic [12:0] val;
    logic        closes;
    logic        fin;
    logic        rw;
    res_t        outs [2];
    int          n;
    n = 0;
    fin = 1'b0;
    rw = 1'b0;
    if (st) begin
      want_line = 1'b1;
      pt_count = '0;
      byte_count = '0;
      frame_idle = 1'b0;
    end
    if (frame_idle) return;
    if (b == TERM_BYTE) begin
      val = TERM_SCALED;
    end else if (want_line) begin
      val = scaled_level(b);
      cur_y = val;
      want_line = 1'b0;
    end else begin
      closes = b > LINE_CLOSE;
      val = scaled_level(closes ? b - LINE_CLOSE : b);
      outs[n] = '{kind: KIND_POINT, y_value: cur_y, x_value: val, end_index: '0,
                  rewind: 1'b0, bank: bk, last: 1'b0};
      n++;
      pt_count++;
      if (closes) want_line = 1'b1;
    end
    byte_count++;
    if (val == TERM_SCALED) begin
      fin = 1'b1;
    end else if (val == 13'd0) begin
      fin = 1'b1;
      rw = 1'b1;
    end else if (byte_count >= byte_budget) begin
      fin = 1'b1;
    end
    if (fin) begin
      outs[n] = '{kind: KIND_END, y_value: '0, x_value: '0,
                  end_index: (pt_count != 0) ? pt_count - 16'd1 : 16'd0,
                  rewind: rw, bank: bk, last: 1'b0};
      n++;
      frame_idle = 1'b1;
    end
    if (n > 0) outs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(outs[i]);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready)
      decode_byte(in_chan.data_byte, in_chan.frame_start, in_chan.bank_select);
  end

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual kind %0d x %0d",
                 $time, out_chan.kind, out_chan.x_value);
      end else begin
        want = expected_results.pop_front();
        compare_field("kind", 16'(want.kind), 16'(out_chan.kind));
        compare_field("y_value", 16'(want.y_value), 16'(out_chan.y_value));
        compare_field("x_value", 16'(want.x_value), 16'(out_chan.x_value));
        compare_field("end_index", want.end_index, out_chan.end_index);
        compare_field("rewind", 16'(want.rewind), 16'(out_chan.rewind));
        compare_field("bank", 16'(want.bank), 16'(out_chan.bank));
        compare_field("last", 16'(want.last), 16'(out_chan.last));
      end
    end
  end

  function automatic int pick_gap(input logic steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // result side: random stalls, plus a long hold when asked
  initial begin
    int gap;
    out_chan.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_cycles > 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        gap = pick_gap(out_steady);
        if (gap > 0) begin
          out_chan.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic st, input logic bk);
    int gap;
    gap = pick_gap(in_steady);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.data_byte   <= b;
    in_chan.frame_start <= st;
    in_chan.bank_select <= bk;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_budget(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    byte_budget = v;
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      case ($urandom_range(0, 3))
        0: return 8'd0;
        1: return 8'd128;
        2: return 8'd224;
        default: return TERM_BYTE;
      endcase
    end
    if (r < 10) begin
      case ($urandom_range(0, 7))
        0: return 8'd1;
        1: return LINE_CLOSE;
        2: return 8'd97;
        3: return 8'd127;
        4: return 8'd129;
        5: return 8'd223;
        6: return 8'd225;
        default: return 8'd254;
      endcase
    end
    return 8'($urandom_range(1, 254));
  endfunction

  task automatic test_terminators();
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(TERM_BYTE, 1'b1, 1'b0);
    send_byte(8'd1, 1'b1, 1'b1);
    send_byte(8'd0, 1'b0, 1'b1);
    send_byte(8'd254, 1'b1, 1'b0);
    send_byte(LINE_CLOSE, 1'b0, 1'b0);
    send_byte(8'd97, 1'b0, 1'b1);
    send_byte(8'd127, 1'b0, 1'b0);
    send_byte(8'd224, 1'b0, 1'b1);
    send_byte(8'd128, 1'b1, 1'b1);
    send_byte(8'd0, 1'b1, 1'b0);
    send_byte(8'd50, 1'b1, 1'b1);
    send_byte(8'd10, 1'b0, 1'b1);
    send_byte(8'd20, 1'b1, 1'b0);
    send_byte(8'd200, 1'b0, 1'b0);
    send_byte(TERM_BYTE, 1'b0, 1'b1);
    send_byte(8'd7, 1'b0, 1'b0);
    settle();
  endtask

  task automatic test_budget_limits();
    set_budget(16'd1);
    send_byte(8'd10, 1'b1, 1'b0);
    settle();
    set_budget(16'd0);
    send_byte(8'd10, 1'b1, 1'b1);
    settle();
    set_budget(16'd3);
    send_byte(8'd10, 1'b1, 1'b0);
    send_byte(8'd20, 1'b0, 1'b1);
    send_byte(8'd30, 1'b0, 1'b1);
    settle();
  endtask

  task automatic run_frames(input int n_items);
    int          sent;
    int          len;
    int          len_cap;
    logic        bk;
    logic        st;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 19) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        continue;
      end
      len_cap = (byte_budget < 40) ? byte_budget + 2 : 40;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300)
                                        : $urandom_range(1, len_cap);
      bk = 1'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
        st = (i == 0) || ($urandom_range(0, 49) == 0);
        if ($urandom_range(0, 9) == 0) bk = ~bk;
        send_byte(pick_byte(), st, bk);
      end
      sent += len;
    end
    settle();
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    run_frames(60);
  endtask

  task automatic test_random_budgets();
    set_budget(16'hFFFF);
    run_frames(300);
    set_budget(16'($urandom_range(1, 30)));
    run_frames(250);
    in_steady  = 1'b1;
    out_steady = 1'b1;
    set_budget(BUDGET_RESET);
    run_frames(250);
    in_steady  = 1'b0;
    out_steady = 1'b0;
    set_budget(16'($urandom_range(1, 65535)));
    run_frames(250);
    set_budget(16'($urandom_range(1, 8)));
    run_frames(100);
  endtask

  initial begin
    clk = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_chan.valid <= 1'b0;
    in_chan.data_byte <= '0;
    in_chan.frame_start <= 1'b0;
    in_chan.bank_select <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_terminators();
    test_budget_limits();
    test_backpressure();
    test_random_budgets();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #9000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/vfsd_pkg.sv
rtl/vfsd_if.sv
rtl/vector_frame_stream_decoder.sv
rtl/vfsd_checker.sv
test/vector_frame_stream_decoder_tb.sv
